### hdl/sps_pkg.sv
// sps_pkg: shared types, constants and codes of the segment protection shield
// no dependencies; imported by segment_protection_shield_core and sps_exec
`timescale 1ns / 1ps
package sps_pkg;

	localparam int SEGMENTS   = 1024;
	localparam int COUNT_BITS = 6;
	localparam int SEG_W      = $clog2(SEGMENTS);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	typedef enum logic [2:0] {
		OP_RAISE  = 3'd0,
		OP_LOWER  = 3'd1,
		OP_EXPOSE = 3'd2,
		OP_COVER  = 3'd3,
		OP_ENTER  = 3'd4,
		OP_LEAVE  = 3'd5
	} op_t;

	typedef enum logic [3:0] {
		ST_OK             = 4'd0,
		ST_RAISE_OVERLAP  = 4'd1,
		ST_LOWER_UNSET    = 4'd2,
		ST_EXPOSE_OUTSIDE = 4'd3,
		ST_COVER_UNEXPOSED = 4'd4,
		ST_COVER_PROTECTED = 4'd5,
		ST_ENTER_INSIDE   = 4'd6,
		ST_LEAVE_OUTSIDE  = 4'd7,
		ST_COUNT_OVERFLOW = 4'd8
	} status_t;

	typedef enum logic [1:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_EXEC
	} fsm_t;

	typedef struct packed {
		logic [2:0] op;
		logic [9:0] segment;
		logic [1:0] mode_bits;
	} cmd_t;

	typedef struct packed {
		logic       prot_update;
		logic [9:0] affected_segment;
		logic [1:0] new_prot;
		logic       suspend_threads;
		logic       resume_threads;
		logic [3:0] status;
	} rsp_t;

	typedef struct packed {
		logic [1:0]            shield;
		logic [COUNT_BITS-1:0] count;
		logic [1:0]            applied;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// write-back request from the execute logic to the table
	typedef struct packed {
		logic   we;
		entry_t wdata;
		logic   shielded;
	} upd_t;

endpackage

### hdl/segment_protection_shield_core.sv
// segment_protection_shield_core: top level, table RAM, clearing sweep and sequencing
// depends on sps_pkg, sps_ram and sps_exec
// an accepted transaction reads its table entry; FSM_EXEC registers its result and done
// busy in FSM_EXEC holds off a new transaction until the table read-then-write is done
// reset: busy stays high while a clearing sweep zeroes all SEGMENTS (1024) entries
// done is high for one cycle only; the receiver cannot stall
`timescale 1ns / 1ps
module segment_protection_shield_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  sps_pkg::cmd_t  cmd,
	output logic           done,
	output sps_pkg::rsp_t  result
);
	import sps_pkg::*;

	fsm_t             state_q, state_d;
	logic [SEG_W-1:0] clr_q;
	logic             inside_q;
	cmd_t             cmd_s1;
	logic             done_q;
	rsp_t             result_q;

	logic             accept;
	logic             ram_we;
	logic [SEG_W-1:0] ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t           entry;
	upd_t             upd;
	rsp_t             rsp;

	assign busy   = (state_q != FSM_IDLE);
	assign accept = start && !busy;
	assign entry  = entry_t'(ram_rdata);

	sps_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SEGMENTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(cmd.segment[SEG_W-1:0]),
		.rdata(ram_rdata)
	);

	sps_exec u_exec (
		.cmd     (cmd_s1),
		.entry   (entry),
		.shielded(inside_q),
		.upd     (upd),
		.rsp     (rsp)
	);

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = cmd_s1.segment[SEG_W-1:0];
		ram_wdata = upd.wdata;
		case (state_q)
			FSM_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == SEG_W'(SEGMENTS - 1)) begin
					state_d = FSM_IDLE;
				end
			end
			FSM_IDLE: begin
				if (accept) begin
					state_d = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				ram_we  = upd.we;
				state_d = FSM_IDLE;
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= FSM_CLEAR;
			clr_q    <= '0;
			inside_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == FSM_EXEC);
			if (state_q == FSM_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == FSM_EXEC) begin
				inside_q <= upd.shielded;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
		end
		if (state_q == FSM_EXEC) begin
			result_q <= rsp;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

### hdl/sps_ram.sv
// sps_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps
module sps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/sps_exec.sv
// sps_exec: checks one transaction against its table entry and forms the new entry
// depends on sps_pkg
`timescale 1ns / 1ps
module sps_exec (
	input  sps_pkg::cmd_t   cmd,
	input  sps_pkg::entry_t entry,
	input  logic            shielded,
	output sps_pkg::upd_t   upd,
	output sps_pkg::rsp_t   rsp
);
	import sps_pkg::*;

	logic   seg_ok;
	entry_t ne;
	logic   reapply;

	assign seg_ok = 32'(cmd.segment) < SEGMENTS;

	always_comb begin
		ne           = entry;
		reapply      = 1'b0;
		upd.we       = 1'b0;
		upd.shielded = shielded;
		rsp          = '0;
		rsp.status   = ST_OK;
		case (op_t'(cmd.op))
			OP_RAISE: begin
				if (seg_ok) begin
					if ((entry.shield & cmd.mode_bits) != 2'b00) begin
						rsp.status = ST_RAISE_OVERLAP;
					end else begin
						ne.shield = entry.shield | cmd.mode_bits;
						upd.we    = 1'b1;
						reapply   = (entry.count == '0);
					end
				end
			end
			OP_LOWER: begin
				if (seg_ok) begin
					if ((entry.shield & cmd.mode_bits) != cmd.mode_bits) begin
						rsp.status = ST_LOWER_UNSET;
					end else begin
						ne.shield = entry.shield & ~cmd.mode_bits;
						upd.we    = 1'b1;
						reapply   = (entry.count == '0);
					end
				end
			end
			OP_EXPOSE: begin
				if (seg_ok) begin
					if (!shielded) begin
						rsp.status = ST_EXPOSE_OUTSIDE;
					end else if (entry.count == COUNT_MAX) begin
						rsp.status = ST_COUNT_OVERFLOW;
					end else begin
						ne.count   = entry.count + 1'b1;
						ne.applied = 2'b00;
						upd.we     = 1'b1;
						if (entry.applied != 2'b00) begin
							rsp.prot_update      = 1'b1;
							rsp.affected_segment = cmd.segment;
							rsp.new_prot         = 2'b00;
						end
					end
				end
			end
			OP_COVER: begin
				if (seg_ok) begin
					if (entry.applied != 2'b00) begin
						rsp.status = ST_COVER_PROTECTED;
					end else if (entry.count == '0) begin
						rsp.status = ST_COVER_UNEXPOSED;
					end else begin
						ne.count = entry.count - 1'b1;
						upd.we   = 1'b1;
						reapply  = (ne.count == '0);
					end
				end
			end
			OP_ENTER: begin
				if (shielded) begin
					rsp.status = ST_ENTER_INSIDE;
				end else begin
					upd.shielded        = 1'b1;
					rsp.suspend_threads = 1'b1;
				end
			end
			OP_LEAVE: begin
				if (!shielded) begin
					rsp.status = ST_LEAVE_OUTSIDE;
				end else begin
					upd.shielded       = 1'b0;
					rsp.resume_threads = 1'b1;
				end
			end
			default: begin
			end
		endcase
		// protection follows the shield mode once nothing is exposed
		if (reapply && (ne.applied != ne.shield)) begin
			ne.applied           = ne.shield;
			rsp.prot_update      = 1'b1;
			rsp.affected_segment = cmd.segment;
			rsp.new_prot         = ne.shield;
		end
		upd.wdata = ne;
	end

endmodule
